// ===== hw/rtl/dtc_pkg.sv =====
// Shared types, codes and constants of the depth-to-color registration block.
`default_nettype none

package dtc_pkg;

    localparam int NUM_COEF          = 24;
    localparam int COEF_W            = 32;
    localparam int IDX_W             = 5;
    localparam int PIX_W             = 10;
    localparam int DEPTH_W           = 16;
    localparam int COLOR_W           = 12;
    localparam int CFG_W             = 13;
    localparam int CFG_IDX_W         = 4;
    localparam int MAX_DEPTH_COLUMNS = 1024;
    localparam int MAX_DEPTH_ROWS    = 1024;
    localparam int NUM_W             = 64;
    localparam int DIVISOR_W         = 32;
    localparam int DIV_STAGES        = NUM_W;
    localparam int FIFO_DEPTH        = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(1920);
    localparam logic [CFG_W-1:0] ROWS_RESET    = CFG_W'(1080);

    // First slot of each coefficient group.
    localparam int SLOT_INV   = 0;
    localparam int SLOT_ROT   = 6;
    localparam int SLOT_TRANS = 15;
    localparam int SLOT_RGB   = 18;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_MAP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_MAPPED     = 2'd0,
        ST_ZERO_DEPTH = 2'd1,
        ST_OUTSIDE    = 2'd2,
        ST_ZERO_ZC    = 2'd3
    } t_status;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [NUM_COEF-1:0] t_coef_bank;

    typedef struct packed {
        t_op                       operation;
        logic [IDX_W-1:0]          coef_index;
        logic signed [COEF_W-1:0]  coef_value;
        logic [PIX_W-1:0]          pixel_x;
        logic [PIX_W-1:0]          pixel_y;
        logic [DEPTH_W-1:0]        depth_mm;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]   out_x;
        logic [PIX_W-1:0]   out_y;
        logic [COLOR_W-1:0] color_u;
        logic [COLOR_W-1:0] color_v;
        t_status            status;
    } t_out_item;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [DEPTH_W-1:0] depth;
    } t_pix_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             zero_depth;
        logic             zc_zero;
        logic             neg_u;
        logic             neg_v;
    } t_div_tag;

endpackage

`default_nettype wire

// ===== hw/rtl/dtc_fifo.sv =====
// Short queue of pixel transactions between the front and the back.
`default_nettype none

module dtc_fifo
    import dtc_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_pix_item     i_item,
    input  wire logic          i_pop,
    output t_pix_item          o_item,
    output t_queue_status      o_status
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_pix_item              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]       r_wr, r_rd;
    logic [PTR_W:0]         r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + PTR_W'(1);
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    assign o_item         = r_mem[r_rd];
    assign o_status.full  = (r_count == (PTR_W+1)'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full && !i_pop |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop) else $error("queue underflow");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + (PTR_W+1)'(1))
        else $error("queue count did not advance");

endmodule

`default_nettype wire

// ===== hw/rtl/dtc_front.sv =====
// Front: accepts transactions, holds configuration and coefficients, queues pixels.
`default_nettype none

module dtc_front
    import dtc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire t_in_item             i_data,
    output logic                      o_stall,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_queue_status        i_queue,
    input  wire logic                 i_back_busy,
    output logic                      o_push,
    output t_pix_item                 o_push_item,
    output t_coef_bank                o_coef,
    output logic [CFG_W-1:0]          o_columns,
    output logic [CFG_W-1:0]          o_rows
);

    t_coef_bank       r_coef;
    logic [CFG_W-1:0] r_columns, r_rows;
    logic             w_busy, w_accept, w_load;

    // A load waits until no pixel is in flight, so that each pixel sees one
    // consistent coefficient set.
    assign w_busy   = !i_queue.empty || i_back_busy;
    assign o_stall  = i_queue.full || (i_valid && i_data.operation == OP_LOAD && w_busy);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = w_accept && i_data.operation == OP_LOAD;
    assign o_push   = w_accept && i_data.operation == OP_MAP;

    assign o_push_item.x     = i_data.pixel_x;
    assign o_push_item.y     = i_data.pixel_y;
    assign o_push_item.depth = i_data.depth_mm;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_COEF; i++) begin
            if (w_load && i_data.coef_index == IDX_W'(i)) r_coef[i] <= i_data.coef_value;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_COLUMNS) r_columns <= i_cfg_data;
            if (i_cfg_index == CFG_ROWS)    r_rows    <= i_cfg_data;
        end
    end

    assign o_coef    = r_coef;
    assign o_columns = r_columns;
    assign o_rows    = r_rows;

    a_load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !w_busy) else $error("coefficient load while pixels in flight");

endmodule

`default_nettype wire

// ===== hw/rtl/dtc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two numerators.
`default_nettype none

module dtc_div
    import dtc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic [NUM_W-1:0]     i_dvd_u,
    input  wire logic [NUM_W-1:0]     i_dvd_v,
    input  wire logic [DIVISOR_W-1:0] i_divisor,
    input  wire t_div_tag             i_tag,
    output logic                      o_valid,
    output logic [NUM_W-1:0]          o_quot_u,
    output logic [NUM_W-1:0]          o_quot_v,
    output t_div_tag                  o_tag,
    output logic                      o_busy
);

    logic [DIV_STAGES:0]  r_v;
    logic [NUM_W-1:0]     r_qu [DIV_STAGES+1];
    logic [NUM_W-1:0]     r_qv [DIV_STAGES+1];
    logic [DIVISOR_W-1:0] r_ru [DIV_STAGES+1];
    logic [DIVISOR_W-1:0] r_rv [DIV_STAGES+1];
    logic [DIVISOR_W-1:0] r_d  [DIV_STAGES+1];
    t_div_tag             r_tag[DIV_STAGES+1];

    // The remainder stays below the divisor, so its top bit is always clear.
    function automatic logic [DIVISOR_W+NUM_W-1:0] div_step(
        input logic [DIVISOR_W-1:0] rem,
        input logic [NUM_W-1:0]     dvd,
        input logic [DIVISOR_W-1:0] d
    );
        logic [DIVISOR_W-1:0] rs;
        logic [NUM_W-1:0]     ds;
        rs = {rem[DIVISOR_W-2:0], dvd[NUM_W-1]};
        ds = {dvd[NUM_W-2:0], 1'b0};
        if (rs >= d) begin
            rs    = rs - d;
            ds[0] = 1'b1;
        end
        return {rs, ds};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else if (i_en) r_v[0] <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qu[0]  <= i_dvd_u;
            r_qv[0]  <= i_dvd_v;
            r_ru[0]  <= '0;
            r_rv[0]  <= '0;
            r_d[0]   <= i_divisor;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DIVISOR_W+NUM_W-1:0] n_u, n_v;

        always_comb begin
            n_u = div_step(r_ru[s], r_qu[s], r_d[s]);
            n_v = div_step(r_rv[s], r_qv[s], r_d[s]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else if (i_en) r_v[s+1] <= r_v[s];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ru[s+1]  <= n_u[DIVISOR_W+NUM_W-1:NUM_W];
                r_qu[s+1]  <= n_u[NUM_W-1:0];
                r_rv[s+1]  <= n_v[DIVISOR_W+NUM_W-1:NUM_W];
                r_qv[s+1]  <= n_v[NUM_W-1:0];
                r_d[s+1]   <= r_d[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_valid  = r_v[DIV_STAGES];
    assign o_quot_u = r_qu[DIV_STAGES];
    assign o_quot_v = r_qv[DIV_STAGES];
    assign o_tag    = r_tag[DIV_STAGES];
    assign o_busy   = |r_v;

endmodule

`default_nettype wire

// ===== hw/rtl/dtc_back.sv =====
// Back: fixed-point pixel mapping pipeline with the output register.
`default_nettype none

module dtc_back
    import dtc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire t_pix_item        i_q_item,
    output logic                  o_pop,
    input  wire t_coef_bank       i_coef,
    input  wire logic [CFG_W-1:0] i_columns,
    input  wire logic [CFG_W-1:0] i_rows,
    output logic                  o_busy,
    output logic                  o_valid,
    output t_out_item             o_data,
    input  wire logic             i_stall
);

    localparam int CMP_W = 14;
    localparam logic signed [63:0] I32_HI  = 64'sd2147483647;
    localparam logic signed [63:0] I32_LO  = -64'sd2147483648;
    localparam logic signed [63:0] I32_LOS = -64'sd2147483647;
    localparam logic [NUM_W-1:0]   Q_LIMIT = NUM_W'(1) << 52;

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        if (v > I32_HI) return 32'(I32_HI);
        else if (v < I32_LO) return 32'(I32_LO);
        else return 32'(v);
    endfunction

    function automatic logic signed [31:0] sat_sym(input logic signed [63:0] v);
        if (v > I32_HI) return 32'(I32_HI);
        else if (v < I32_LOS) return 32'(I32_LOS);
        else return 32'(v);
    endfunction

    logic w_en;

    logic [8:1]              r_v;
    t_pix_item               r_s [1:8];
    logic signed [42:0]      r1_px0, r1_py1, r1_px3, r1_py4;
    logic signed [44:0]      r2_rx, r2_ry;
    logic signed [61:0]      r3_rxz, r3_ryz;
    logic signed [31:0]      r4_xd, r4_yd;
    logic [23:0]             r4_zd;
    logic signed [63:0]      r5_m [9];
    logic signed [31:0]      r6_c [3];
    logic signed [63:0]      r7_nu0, r7_nu1, r7_nv0, r7_nv1;
    logic signed [31:0]      r7_zc, r8_zc;
    logic                    r7_zz, r8_zz;
    logic signed [64:0]      r8_nu, r8_nv;

    logic [PIX_W-1:0]        w_xm, w_ym;
    logic signed [35:0]      w_acc [3];
    logic [NUM_W-1:0]        w_mag_u, w_mag_v;
    logic [DIVISOR_W-1:0]    w_divisor;
    t_div_tag                w_tag;

    logic                    w_div_valid, w_div_busy;
    logic [NUM_W-1:0]        w_quot_u, w_quot_v;
    t_div_tag                w_div_tag;

    logic                    rA_v;
    logic signed [53:0]      rA_qu, rA_qv;
    t_div_tag                rA_tag;
    logic [52:0]             w_qcu, w_qcv;

    logic signed [54:0]      w_valu, w_valv, w_fu, w_fv;
    logic                    w_bad_u, w_bad_v;
    t_status                 w_status;

    logic                    r_out_valid;
    t_out_item               r_out;

    assign w_en  = !r_out_valid || !i_stall;
    assign o_pop = w_en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[7:1], i_q_valid};
        end
    end

    // Pixel coordinates beyond the depth image size are clamped for the math.
    always_comb begin
        w_xm = (CMP_W'(i_q_item.x) > CMP_W'(MAX_DEPTH_COLUMNS - 1))
             ? PIX_W'(MAX_DEPTH_COLUMNS - 1) : i_q_item.x;
        w_ym = (CMP_W'(i_q_item.y) > CMP_W'(MAX_DEPTH_ROWS - 1))
             ? PIX_W'(MAX_DEPTH_ROWS - 1) : i_q_item.y;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_acc[k] = 36'(r5_m[3*k] >>> 30) + 36'(r5_m[3*k+1] >>> 30)
                     + 36'(r5_m[3*k+2] >>> 30) + 36'(i_coef[SLOT_TRANS+k] >>> 8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s[1] <= i_q_item;
            for (int i = 2; i <= 8; i++) r_s[i] <= r_s[i-1];

            r1_px0 <= $signed({1'b0, w_xm}) * i_coef[SLOT_INV+0];
            r1_py1 <= $signed({1'b0, w_ym}) * i_coef[SLOT_INV+1];
            r1_px3 <= $signed({1'b0, w_xm}) * i_coef[SLOT_INV+3];
            r1_py4 <= $signed({1'b0, w_ym}) * i_coef[SLOT_INV+4];

            r2_rx <= 45'(r1_px0) + 45'(r1_py1) + 45'(i_coef[SLOT_INV+2]);
            r2_ry <= 45'(r1_px3) + 45'(r1_py4) + 45'(i_coef[SLOT_INV+5]);

            r3_rxz <= r2_rx * $signed({1'b0, r_s[2].depth});
            r3_ryz <= r2_ry * $signed({1'b0, r_s[2].depth});

            r4_xd <= sat_s32(64'(r3_rxz >>> 22));
            r4_yd <= sat_s32(64'(r3_ryz >>> 22));
            r4_zd <= {r_s[3].depth, 8'd0};

            for (int k = 0; k < 3; k++) begin
                r5_m[3*k]   <= r4_xd * i_coef[SLOT_ROT+3*k];
                r5_m[3*k+1] <= r4_yd * i_coef[SLOT_ROT+3*k+1];
                r5_m[3*k+2] <= $signed({1'b0, r4_zd}) * i_coef[SLOT_ROT+3*k+2];
            end

            for (int k = 0; k < 3; k++) r6_c[k] <= sat_sym(64'(w_acc[k]));

            r7_nu0 <= r6_c[0] * i_coef[SLOT_RGB+0];
            r7_nu1 <= r6_c[1] * i_coef[SLOT_RGB+1];
            r7_nv0 <= r6_c[0] * i_coef[SLOT_RGB+3];
            r7_nv1 <= r6_c[1] * i_coef[SLOT_RGB+4];
            r7_zc  <= r6_c[2];
            r7_zz  <= (r6_c[2] == '0);

            r8_nu <= 65'(r7_nu0) + 65'(r7_nu1);
            r8_nv <= 65'(r7_nv0) + 65'(r7_nv1);
            r8_zc <= r7_zc;
            r8_zz <= r7_zz;
        end
    end

    // Sign and magnitude for the divider; the quotient truncates toward zero.
    always_comb begin
        w_mag_u   = r8_nu[64] ? NUM_W'(-r8_nu) : NUM_W'(r8_nu);
        w_mag_v   = r8_nv[64] ? NUM_W'(-r8_nv) : NUM_W'(r8_nv);
        w_divisor = r8_zc[31] ? DIVISOR_W'(-r8_zc) : DIVISOR_W'(r8_zc);
        w_tag.x          = r_s[8].x;
        w_tag.y          = r_s[8].y;
        w_tag.zero_depth = (r_s[8].depth == '0);
        w_tag.zc_zero    = r8_zz;
        w_tag.neg_u      = r8_nu[64] ^ r8_zc[31];
        w_tag.neg_v      = r8_nv[64] ^ r8_zc[31];
    end

    dtc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (r_v[8]),
        .i_dvd_u   (w_mag_u),
        .i_dvd_v   (w_mag_v),
        .i_divisor (w_divisor),
        .i_tag     (w_tag),
        .o_valid   (w_div_valid),
        .o_quot_u  (w_quot_u),
        .o_quot_v  (w_quot_v),
        .o_tag     (w_div_tag),
        .o_busy    (w_div_busy)
    );

    always_comb begin
        w_qcu = (w_quot_u > Q_LIMIT) ? 53'(Q_LIMIT) : w_quot_u[52:0];
        w_qcv = (w_quot_v > Q_LIMIT) ? 53'(Q_LIMIT) : w_quot_v[52:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rA_v <= 1'b0;
        else if (w_en) rA_v <= w_div_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rA_qu  <= w_div_tag.neg_u ? -$signed({1'b0, w_qcu}) : $signed({1'b0, w_qcu});
            rA_qv  <= w_div_tag.neg_v ? -$signed({1'b0, w_qcv}) : $signed({1'b0, w_qcv});
            rA_tag <= w_div_tag;
        end
    end

    // Add the principal point, then shift out the Q.20 fraction toward zero.
    always_comb begin
        w_valu = 55'(rA_qu) + 55'(i_coef[SLOT_RGB+2]);
        w_valv = 55'(rA_qv) + 55'(i_coef[SLOT_RGB+5]);
        w_fu   = (w_valu + (w_valu[54] ? 55'sd1048575 : 55'sd0)) >>> 20;
        w_fv   = (w_valv + (w_valv[54] ? 55'sd1048575 : 55'sd0)) >>> 20;
        w_bad_u = w_fu[54] || (|w_fu[53:COLOR_W]) || ({1'b0, w_fu[COLOR_W-1:0]} >= i_columns);
        w_bad_v = w_fv[54] || (|w_fv[53:COLOR_W]) || ({1'b0, w_fv[COLOR_W-1:0]} >= i_rows);
        priority if (rA_tag.zero_depth) w_status = ST_ZERO_DEPTH;
        else if (rA_tag.zc_zero)        w_status = ST_ZERO_ZC;
        else if (w_bad_u || w_bad_v)    w_status = ST_OUTSIDE;
        else                            w_status = ST_MAPPED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_en) r_out_valid <= rA_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.out_x   <= rA_tag.x;
            r_out.out_y   <= rA_tag.y;
            r_out.color_u <= (w_status == ST_MAPPED) ? w_fu[COLOR_W-1:0] : '0;
            r_out.color_v <= (w_status == ST_MAPPED) ? w_fv[COLOR_W-1:0] : '0;
            r_out.status  <= w_status;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_busy  = (|r_v) || w_div_busy || rA_v || r_out_valid;

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> w_en && i_q_valid) else $error("queue popped while pipeline held");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != ST_MAPPED |-> r_out.color_u == '0 && r_out.color_v == '0)
        else $error("unmapped pixel carries a color position");

endmodule

`default_nettype wire

// ===== hw/rtl/depth_to_color_registration_unit.sv =====
// Top level of the depth-to-color pixel registration block.
// Throughput: one pixel per cycle, since every math stage and all 64 steps of the Zc
// quotient are pipelined; a stalled result holds the whole back and the queue absorbs four.
// A coefficient load is held off until no pixel is in flight.
// Reset clears all valid bits and sets the color bounds to 1920 by 1080;
// the coefficient store is undefined until written.
`default_nettype none

module depth_to_color_registration_unit
    import dtc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire t_in_item             i_data,
    output logic                      o_stall,
    output logic                      o_valid,
    output t_out_item                 o_data,
    input  wire logic                 i_stall,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // The front classifies each input transaction. Loads go straight into
    // the coefficient store; pixels are queued for the back.
    t_queue_status    w_queue;
    logic             w_push, w_pop, w_back_busy;
    t_pix_item        w_push_item, w_pop_item;
    t_coef_bank       w_coef;
    logic [CFG_W-1:0] w_columns, w_rows;

    dtc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data       (i_data),
        .o_stall      (o_stall),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_queue      (w_queue),
        .i_back_busy  (w_back_busy),
        .o_push       (w_push),
        .o_push_item  (w_push_item),
        .o_coef       (w_coef),
        .o_columns    (w_columns),
        .o_rows       (w_rows)
    );

    // The queue lets the front keep accepting while the back is held by a
    // stalled result.
    dtc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_pop_item),
        .o_status (w_queue)
    );

    // The back runs the projection math; the whole pipeline advances
    // together whenever its output register can move.
    dtc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!w_queue.empty),
        .i_q_item  (w_pop_item),
        .o_pop     (w_pop),
        .i_coef    (w_coef),
        .i_columns (w_columns),
        .i_rows    (w_rows),
        .o_busy    (w_back_busy),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

`default_nettype wire
